### rtl/core/clns_pkg.sv
// Package for the character-LCD nibble sequencer: request, phase and job types,
// request codes, hold times and the initialization phase table.
// No dependencies.
package clns_pkg;

  localparam int QUEUE_DEPTH = 2;

  // Request codes
  localparam logic [2:0] REQ_INIT   = 3'd0;
  localparam logic [2:0] REQ_CLEAR  = 3'd1;
  localparam logic [2:0] REQ_HOME   = 3'd2;
  localparam logic [2:0] REQ_CURSOR = 3'd3;
  localparam logic [2:0] REQ_CHAR   = 3'd4;

  // Display commands
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;
  localparam logic [3:0] NIB_WAKE      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;
  localparam logic [7:0] MAX_ROW       = 8'd1;
  localparam logic [7:0] MAX_COL       = 8'h0F;

  // Hold times in milliseconds
  localparam logic [6:0] HOLD_SETTLE     = 7'd100;
  localparam logic [6:0] HOLD_NIBBLE     = 7'd1;
  localparam logic [6:0] HOLD_BYTE_TAIL  = 7'd3;
  localparam logic [6:0] HOLD_SLOW_TAIL  = 7'd5;
  localparam logic [6:0] HOLD_CLEAR_INIT = 7'd8;
  localparam logic [6:0] HOLD_WAKE0      = 7'd11;
  localparam logic [6:0] HOLD_WAKE1      = 7'd6;
  localparam logic [6:0] HOLD_WAKE2      = 7'd3;

  // Phase counts
  localparam int INIT_PHASES = 29;
  localparam int BYTE_PHASES = 4;
  localparam int STEP_W      = $clog2(INIT_PHASES);
  localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_PHASES - 1);
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP = STEP_W'(BYTE_PHASES - 1);
  localparam logic [STEP_W-1:0] INIT_BYTE_BASE = STEP_W'(9);

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] char_code;
  } req_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] data_nibble;
    logic       enable;
    logic [6:0] hold_ms;
    logic       last;
  } phase_t;

  // One classified request, as queued for the back end
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
    logic [6:0] tail_hold;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] cmd;
    case (idx)
      3'd0:    cmd = CMD_FUNC_SET;
      3'd1:    cmd = CMD_DISP_OFF;
      3'd2:    cmd = CMD_CLEAR;
      3'd3:    cmd = CMD_ENTRY;
      default: cmd = CMD_DISP_ON;
    endcase
    return cmd;
  endfunction

  // Phase of the initialization sequence at a given step
  function automatic phase_t init_phase(input logic [STEP_W-1:0] step);
    phase_t             ph;
    logic [STEP_W-1:0]  rel;
    logic [2:0]         bidx;
    logic [7:0]         cmd;
    ph = '0;
    ph.last = (step == INIT_LAST_STEP);
    rel  = step - INIT_BYTE_BASE;
    bidx = rel[4:2];
    cmd  = init_cmd(bidx);
    if (step == '0) begin
      ph.hold_ms = HOLD_SETTLE;
    end else if (step < INIT_BYTE_BASE) begin
      // wake-up nibbles: odd steps raise enable, even steps drop it
      ph.data_nibble = (step > STEP_W'(6)) ? NIB_4BIT : NIB_WAKE;
      ph.enable      = step[0];
      if (step[0]) begin
        ph.hold_ms = HOLD_NIBBLE;
      end else begin
        case (step)
          STEP_W'(2): ph.hold_ms = HOLD_WAKE0;
          STEP_W'(4): ph.hold_ms = HOLD_WAKE1;
          default:    ph.hold_ms = HOLD_WAKE2;
        endcase
      end
    end else begin
      ph.data_nibble = rel[1] ? cmd[3:0] : cmd[7:4];
      ph.enable      = ~rel[0];
      if (rel[1:0] == 2'd3) begin
        ph.hold_ms = (cmd == CMD_CLEAR) ? HOLD_CLEAR_INIT : HOLD_BYTE_TAIL;
      end else begin
        ph.hold_ms = HOLD_NIBBLE;
      end
    end
    return ph;
  endfunction

endpackage

### rtl/core/char_lcd_nibble_sequencer.sv
// Top level of the 4-bit character-LCD bus sequencer: front decoder, job queue,
// phase back end. Uses clns_pkg, clns_front, clns_queue, clns_back.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   request  | req_valid/req_stall  | req   (clns_pkg::req_t)
//   phase    | phase_valid/phase_stall | phase (clns_pkg::phase_t)
//
// A request is loaded from the queue into the back end, then one phase per
// cycle unless phase_stall holds it: 29 phases for init, 4 for a byte
// request, set by the back end's phase counter. Unknown request codes transfer and emit nothing.
// rst clears queue pointers, back-end state and phase_valid.
// A stalled phase holds in the output register while the queue keeps
// taking requests until it fills.
module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  clns_pkg::req_t   req,
  output logic             phase_valid,
  input  logic             phase_stall,
  output clns_pkg::phase_t phase
);

  logic           q_full;
  logic           q_not_empty;
  logic           push;
  logic           pop;
  clns_pkg::job_t push_job;
  clns_pkg::job_t q_head;

  clns_front u_front (
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  clns_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .phase_valid (phase_valid),
    .phase_stall (phase_stall),
    .phase       (phase)
  );

endmodule

### rtl/core/clns_front.sv
// Front end: decodes a request into a queued job (init sequence or one byte).
// Uses clns_pkg.
module clns_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  clns_pkg::req_t req,
  input  logic          q_full,
  output logic          push,
  output clns_pkg::job_t job
);

  logic       known;
  logic [7:0] row_c;
  logic [7:0] col_c;
  logic [7:0] addr;

  assign row_c = (req.row > clns_pkg::MAX_ROW) ? clns_pkg::MAX_ROW : req.row;
  assign col_c = (req.col > clns_pkg::MAX_COL) ? clns_pkg::MAX_COL : req.col;
  assign addr  = clns_pkg::CMD_SET_DDRAM | (col_c +
                 ((row_c == clns_pkg::MAX_ROW) ? clns_pkg::ROW1_OFFSET : 8'd0));

  always_comb begin
    known = 1'b1;
    job   = '0;
    job.tail_hold = clns_pkg::HOLD_BYTE_TAIL;
    unique case (req.req_type)
      clns_pkg::REQ_INIT: begin
        job.is_init = 1'b1;
      end
      clns_pkg::REQ_CLEAR: begin
        job.byte_val  = clns_pkg::CMD_CLEAR;
        job.tail_hold = clns_pkg::HOLD_SLOW_TAIL;
      end
      clns_pkg::REQ_HOME: begin
        job.byte_val  = clns_pkg::CMD_HOME;
        job.tail_hold = clns_pkg::HOLD_SLOW_TAIL;
      end
      clns_pkg::REQ_CURSOR: begin
        job.byte_val = addr;
      end
      clns_pkg::REQ_CHAR: begin
        job.rs       = 1'b1;
        job.byte_val = req.char_code;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // Unknown requests transfer but push nothing
  assign req_stall = q_full;
  assign push      = req_valid && !q_full && known;

endmodule

### rtl/core/clns_queue.sv
// Short job queue between front and back end.
// Uses clns_pkg for the job type.
module clns_queue #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  clns_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output clns_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clns_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/clns_back.sv
// Back end: walks one job through its pin phases into a registered output.
// Uses clns_pkg for job and phase types and the init table.
module clns_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_not_empty,
  input  clns_pkg::job_t  q_head,
  output logic            pop,
  output logic            phase_valid,
  input  logic            phase_stall,
  output clns_pkg::phase_t phase
);

  logic                        busy;
  clns_pkg::job_t              job;
  logic [clns_pkg::STEP_W-1:0] step;
  clns_pkg::phase_t            cur;
  clns_pkg::phase_t            init_ph;
  logic                        advance;

  assign init_ph = clns_pkg::init_phase(step);

  always_comb begin
    if (job.is_init) begin
      cur = init_ph;
    end else begin
      cur.reg_select  = job.rs;
      cur.data_nibble = step[1] ? job.byte_val[3:0] : job.byte_val[7:4];
      cur.enable      = ~step[0];
      cur.last        = (step == clns_pkg::BYTE_LAST_STEP);
      cur.hold_ms     = cur.last ? job.tail_hold : clns_pkg::HOLD_NIBBLE;
    end
  end

  assign advance = busy && (!phase_valid || !phase_stall);
  assign pop     = !busy && q_not_empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
    end
    if (advance) begin
      phase <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      step        <= '0;
      phase_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        step <= '0;
      end else if (advance) begin
        // drop busy after the final phase, else move to the next one
        if (cur.last) begin
          busy <= 1'b0;
        end else begin
          step <= step + 1'b1;
        end
      end
      if (advance) begin
        phase_valid <= 1'b1;
      end else if (!phase_stall) begin
        phase_valid <= 1'b0;
      end
    end
  end

endmodule

### tb/char_lcd_nibble_sequencer_test.sv
`timescale 1ns / 100ps
// Testbench for char_lcd_nibble_sequencer: request stimulus, phase predictor and scoreboard.
// Depends on clns_pkg and the char_lcd_nibble_sequencer RTL.
module char_lcd_nibble_sequencer_test;
  import clns_pkg::*;

  // Codes the block has no meaning for; it must take them and emit nothing
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_MID   = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam int         DRAIN_CYCLES      = 40;
  localparam int         HOLD_OFF_CYCLES   = 160;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   req_valid = 1'b0;
  logic   req_stall;
  req_t   req = '0;
  logic   phase_valid;
  logic   phase_stall = 1'b0;
  phase_t phase;

  phase_t expected_phases[$];
  int     errors = 0;
  int     phases_checked = 0;
  int     requests_sent = 0;
  int     sent_by_code[8];
  bit     tx_idle_on = 1'b0;
  bit     rx_idle_on = 1'b0;
  logic   hold_off = 1'b0;
  int     rx_burst = 0;

  char_lcd_nibble_sequencer dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .phase_valid(phase_valid),
    .phase_stall(phase_stall),
    .phase      (phase)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("[char_lcd_nibble_sequencer] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic void add_phase(logic rs, logic [3:0] nib, logic en, logic [6:0] hold);
    phase_t p;
    p.reg_select  = rs;
    p.data_nibble = nib;
    p.enable      = en;
    p.hold_ms     = hold;
    p.last        = 1'b0;
    expected_phases.push_back(p);
  endfunction

  // Enable-high phase for 1 ms, then enable-low with any extra wait folded in
  function automatic void add_nibble(logic rs, logic [3:0] nib, logic [6:0] extra);
    add_phase(rs, nib, 1'b1, 7'd1);
    add_phase(rs, nib, 1'b0, 7'd1 + extra);
  endfunction

  function automatic void add_byte(logic [7:0] value, logic rs, logic [6:0] extra);
    add_nibble(rs, value[7:4], 7'd0);
    add_nibble(rs, value[3:0], 7'd2 + extra);
  endfunction

  function automatic void predict_phases(req_t r);
    int         n0;
    logic [7:0] row_c;
    logic [7:0] col_c;
    phase_t     p;
    n0 = expected_phases.size();
    case (r.req_type)
      REQ_INIT: begin
        add_phase(1'b0, 4'h0, 1'b0, HOLD_SETTLE);
        add_nibble(1'b0, NIB_WAKE, 7'd10);
        add_nibble(1'b0, NIB_WAKE, 7'd5);
        add_nibble(1'b0, NIB_WAKE, 7'd2);
        add_nibble(1'b0, NIB_4BIT, 7'd2);
        add_byte(CMD_FUNC_SET, 1'b0, 7'd0);
        add_byte(CMD_DISP_OFF, 1'b0, 7'd0);
        add_byte(CMD_CLEAR,    1'b0, 7'd5);
        add_byte(CMD_ENTRY,    1'b0, 7'd0);
        add_byte(CMD_DISP_ON,  1'b0, 7'd0);
      end
      REQ_CLEAR: add_byte(CMD_CLEAR, 1'b0, 7'd2);
      REQ_HOME:  add_byte(CMD_HOME,  1'b0, 7'd2);
      REQ_CURSOR: begin
        row_c = (r.row > MAX_ROW) ? MAX_ROW : r.row;
        col_c = (r.col > MAX_COL) ? MAX_COL : r.col;
        add_byte(CMD_SET_DDRAM | (col_c + ((row_c == MAX_ROW) ? ROW1_OFFSET : 8'h00)),
                 1'b0, 7'd0);
      end
      REQ_CHAR: add_byte(r.char_code, 1'b1, 7'd0);
      default: ;
    endcase
    if (expected_phases.size() > n0) begin
      p = expected_phases[expected_phases.size() - 1];
      p.last = 1'b1;
      expected_phases[expected_phases.size() - 1] = p;
    end
  endfunction

  // ------------------------------------------------------------------ checking
  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at phase %0d: %s got %0h expected %0h", phases_checked, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    phase_t want;
    if (!rst && phase_valid && !phase_stall) begin
      if (expected_phases.size() == 0) begin
        report_mismatch("unexpected phase", phase, 0);
      end else begin
        want = expected_phases.pop_front();
        if (phase.reg_select !== want.reg_select)
          report_mismatch("reg_select", phase.reg_select, want.reg_select);
        if (phase.data_nibble !== want.data_nibble)
          report_mismatch("data_nibble", phase.data_nibble, want.data_nibble);
        if (phase.enable !== want.enable)
          report_mismatch("enable", phase.enable, want.enable);
        if (phase.hold_ms !== want.hold_ms)
          report_mismatch("hold_ms", phase.hold_ms, want.hold_ms);
        if (phase.last !== want.last)
          report_mismatch("last", phase.last, want.last);
      end
      phases_checked++;
    end
  end

  // Phase receiver: long hold-off on request, random stall bursts while rx_idle_on is set, no stall otherwise
  always @(posedge clk) begin
    if (hold_off) begin
      phase_stall <= 1'b1;
    end else if (!rx_idle_on) begin
      phase_stall <= 1'b0;
    end else if (rx_burst > 0) begin
      phase_stall <= 1'b1;
      rx_burst <= rx_burst - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      phase_stall <= 1'b1;
      rx_burst <= $urandom_range(0, 10);
    end else begin
      phase_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------ stimulus
  function automatic req_t make_req(logic [2:0] code, logic [7:0] row, logic [7:0] col,
                                    logic [7:0] ch);
    req_t r;
    r.req_type  = code;
    r.row       = row;
    r.col       = col;
    r.char_code = ch;
    return r;
  endfunction

  function automatic req_t random_request();
    int         roll;
    logic [2:0] code;
    logic [7:0] row;
    logic [7:0] col;
    roll = $urandom_range(0, 99);
    if (roll < 8)       code = REQ_INIT;
    else if (roll < 20) code = REQ_CLEAR;
    else if (roll < 32) code = REQ_HOME;
    else if (roll < 60) code = REQ_CURSOR;
    else if (roll < 95) code = REQ_CHAR;
    else                code = 3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST));
    // mostly in-range positions, sometimes anything to exercise the clamp
    row = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 1));
    col = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 15));
    return make_req(code, row, col, 8'($urandom_range(0, 255)));
  endfunction

  // Called just after a rising edge; returns at the edge that took the transfer
  task automatic send_request(req_t r);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    predict_phases(r);
    requests_sent++;
    sent_by_code[r.req_type]++;
  endtask

  task automatic test_directed();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_request(make_req(REQ_INIT,   8'h00, 8'h00, 8'h00));
    send_request(make_req(REQ_CLEAR,  8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_HOME,   8'h00, 8'h00, 8'h00));
    send_request(make_req(REQ_HOME,   8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_CURSOR, 8'h00, 8'h00, 8'hFF));
    send_request(make_req(REQ_CURSOR, 8'h01, 8'h0F, 8'h00));
    send_request(make_req(REQ_CURSOR, 8'h01, 8'h00, 8'h00));
    send_request(make_req(REQ_CURSOR, 8'h00, 8'h10, 8'h00));
    send_request(make_req(REQ_CURSOR, 8'h02, 8'h07, 8'h00));
    send_request(make_req(REQ_CURSOR, 8'hFF, 8'hFF, 8'h00));
    send_request(make_req(REQ_CHAR,   8'h00, 8'h00, 8'h00));
    send_request(make_req(REQ_CHAR,   8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_CHAR,   8'h01, 8'h0F, 8'hA5));
    send_request(make_req(REQ_CHAR,   8'h00, 8'h00, 8'h5A));
    send_request(make_req(REQ_UNKNOWN_FIRST, 8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_UNKNOWN_MID,   8'h00, 8'h00, 8'h00));
    send_request(make_req(REQ_UNKNOWN_LAST,  8'hFF, 8'h0F, 8'h41));
    send_request(make_req(REQ_CHAR,   8'h00, 8'h00, 8'h41));
    send_request(make_req(REQ_INIT,   8'hFF, 8'hFF, 8'hFF));
    send_request(make_req(REQ_CLEAR,  8'h00, 8'h00, 8'h00));
  endtask

  task automatic test_random(int count, bit with_idle);
    tx_idle_on = with_idle;
    rx_idle_on = with_idle;
    repeat (count) send_request(random_request());
  endtask

  // Hold the phase side off while requests keep coming, so the queue fills
  task automatic test_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        repeat (4) send_request(make_req(REQ_CHAR, 8'h00, 8'h00, 8'($urandom_range(0, 255))));
        send_request(make_req(REQ_INIT, 8'h00, 8'h00, 8'h00));
        repeat (6) send_request(random_request());
      end
    join
  endtask

  task automatic drain_and_check();
    req_valid <= 1'b0;
    while (expected_phases.size() != 0) @(posedge clk);
    // unknown codes emit nothing; give any stray phase time to show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_phases.size() != 0)
      report_mismatch("phases never seen", 0, expected_phases.size());
  endtask

  initial begin
    foreach (sent_by_code[i]) sent_by_code[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(260, 1'b1);
    test_backpressure();
    test_random(120, 1'b0);
    drain_and_check();
    $display("covered %0d requests: init %0d, clear %0d, home %0d, cursor %0d, char %0d",
             requests_sent, sent_by_code[REQ_INIT], sent_by_code[REQ_CLEAR],
             sent_by_code[REQ_HOME], sent_by_code[REQ_CURSOR], sent_by_code[REQ_CHAR]);
    $display("%0d unknown codes taken, %0d phases compared, %0d mismatches",
             requests_sent - sent_by_code[REQ_INIT] - sent_by_code[REQ_CLEAR]
             - sent_by_code[REQ_HOME] - sent_by_code[REQ_CURSOR] - sent_by_code[REQ_CHAR],
             phases_checked, errors);
    if (errors == 0) begin
      $display("[char_lcd_nibble_sequencer] OK");
    end else begin
      $display("[char_lcd_nibble_sequencer] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/clns_pkg.sv
rtl/core/clns_front.sv
rtl/core/clns_queue.sv
rtl/core/clns_back.sv
rtl/core/char_lcd_nibble_sequencer.sv
tb/char_lcd_nibble_sequencer_test.sv
